>>> rtl/ctd_pkg.sv
// ----------------------------------------------------------------------------
// ctd_pkg: shared types and helpers for the compressed texel decoder
// Texture format codes, the RGBA result type and the fixed-point helpers
// that expand 565 endpoints and form the one-third and half-way interpolants.
// ----------------------------------------------------------------------------
package ctd_pkg;

  // Texture format register codes
  typedef enum logic [1:0] {
    FMT_BGRA8 = 2'd0,
    FMT_DXT1  = 2'd1,
    FMT_DXT3  = 2'd2,
    FMT_R565  = 2'd3
  } fmt_e;

  // One decoded texel
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  // Reciprocal constants: floor(m / D) = (m * K) >> 20 for 31 and 63, >> 11 for 3, over the used range
  localparam logic [15:0] Recip31 = 16'd33826;
  localparam logic [15:0] Recip63 = 16'd16645;
  localparam logic [9:0]  Recip3  = 10'd683;

  // Expand a 5-bit channel as v*255/31, truncated
  function automatic logic [7:0] expand5(input logic [4:0] v);
    logic [12:0] m;
    logic [28:0] p;
    m = {v, 8'b0} - {8'b0, v};
    p = {16'b0, m} * {13'b0, Recip31};
    return p[27:20];
  endfunction

  // Expand a 6-bit channel as v*255/63, truncated
  function automatic logic [7:0] expand6(input logic [5:0] v);
    logic [13:0] m;
    logic [29:0] p;
    m = {v, 8'b0} - {8'b0, v};
    p = {16'b0, m} * {14'b0, Recip63};
    return p[27:20];
  endfunction

  // (2p + q + 1) / 3; the sum stays below 768
  function automatic logic [7:0] third_near(input logic [7:0] p, input logic [7:0] q);
    logic [9:0]  s;
    logic [20:0] m;
    s = {1'b0, p, 1'b0} + {2'b0, q} + 10'd1;
    m = {11'b0, s} * {11'b0, Recip3};
    return m[18:11];
  endfunction

  // (p + q + 1) / 2
  function automatic logic [7:0] half_of(input logic [7:0] p, input logic [7:0] q);
    logic [8:0] s;
    s = {1'b0, p} + {1'b0, q} + 9'd1;
    return s[8:1];
  endfunction

endpackage

>>> rtl/ctd_texel_if.sv
// ----------------------------------------------------------------------------
// ctd_texel_if: texel request channel
// Carries the fetched source bits and the texel position in its 4x4 block.
// ----------------------------------------------------------------------------
interface ctd_texel_if;
  logic        valid;
  logic        ready;
  logic [63:0] color_block;
  logic [63:0] alpha_block;
  logic [1:0]  texel_col;
  logic [1:0]  texel_row;

  modport source (output valid, color_block, alpha_block, texel_col, texel_row,
                  input ready);
  modport sink   (input valid, color_block, alpha_block, texel_col, texel_row,
                  output ready);
endinterface

>>> rtl/ctd_rgba_if.sv
// ----------------------------------------------------------------------------
// ctd_rgba_if: decoded texel channel
// Carries one RGBA8 texel per request.
// ----------------------------------------------------------------------------
interface ctd_rgba_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

>>> rtl/ctd_cfg_if.sv
// ----------------------------------------------------------------------------
// ctd_cfg_if: configuration write channel
// Carries a new texture format value.
// ----------------------------------------------------------------------------
interface ctd_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] texture_format;

  modport source (output valid, texture_format, input ready);
  modport sink   (input valid, texture_format, output ready);
endinterface

>>> rtl/ctd_dxt_color.sv
// ----------------------------------------------------------------------------
// ctd_dxt_color: DXT color block decode
// Expands the two 565 endpoints, picks the texel's 2-bit index and forms
// the endpoint, interpolant or transparent black color.
// ----------------------------------------------------------------------------
module ctd_dxt_color (
  input  logic [63:0]   color_block_i,
  input  logic [3:0]    texel_idx_i,
  input  logic          four_only_i,
  output ctd_pkg::rgba_t rgba_o
);
  import ctd_pkg::*;

  logic [15:0] c0, c1;
  logic [31:0] idx_bits;
  logic [1:0]  sel;
  logic        three;
  logic [7:0]  r0, g0, b0, r1, g1, b1;

  assign c0       = color_block_i[15:0];
  assign c1       = color_block_i[31:16];
  assign idx_bits = color_block_i[63:32];
  assign sel      = idx_bits[{texel_idx_i, 1'b0} +: 2];
  assign three    = !four_only_i && (c0 <= c1);

  // Expand both endpoints
  assign r0 = expand5(c0[15:11]);
  assign g0 = expand6(c0[10:5]);
  assign b0 = expand5(c0[4:0]);
  assign r1 = expand5(c1[15:11]);
  assign g1 = expand6(c1[10:5]);
  assign b1 = expand5(c1[4:0]);

  // Select the palette entry
  always_comb begin
    rgba_o.alpha = 8'd255;
    case (sel)
      2'd0: begin
        rgba_o.red   = r0;
        rgba_o.green = g0;
        rgba_o.blue  = b0;
      end
      2'd1: begin
        rgba_o.red   = r1;
        rgba_o.green = g1;
        rgba_o.blue  = b1;
      end
      2'd2: begin
        if (three) begin
          rgba_o.red   = half_of(r0, r1);
          rgba_o.green = half_of(g0, g1);
          rgba_o.blue  = half_of(b0, b1);
        end else begin
          rgba_o.red   = third_near(r0, r1);
          rgba_o.green = third_near(g0, g1);
          rgba_o.blue  = third_near(b0, b1);
        end
      end
      default: begin
        if (three) begin
          rgba_o.red   = 8'd0;
          rgba_o.green = 8'd0;
          rgba_o.blue  = 8'd0;
          rgba_o.alpha = 8'd0;
        end else begin
          rgba_o.red   = third_near(r1, r0);
          rgba_o.green = third_near(g1, g0);
          rgba_o.blue  = third_near(b1, b0);
        end
      end
    endcase
  end

endmodule

>>> rtl/ctd_format_mux.sv
// ----------------------------------------------------------------------------
// ctd_format_mux: per-format texel decode
// Decodes one registered request into RGBA8 for the selected format.
// ----------------------------------------------------------------------------
module ctd_format_mux (
  input  ctd_pkg::fmt_e  fmt_i,
  input  logic [63:0]    color_block_i,
  input  logic [63:0]    alpha_block_i,
  input  logic [1:0]     texel_col_i,
  input  logic [1:0]     texel_row_i,
  output ctd_pkg::rgba_t rgba_o
);
  import ctd_pkg::*;

  logic [3:0] texel_idx;
  logic [3:0] alpha4;
  rgba_t      dxt_rgba;

  assign texel_idx = {texel_row_i, texel_col_i};
  assign alpha4    = alpha_block_i[{texel_idx, 2'b0} +: 4];

  ctd_dxt_color u_dxt (
    .color_block_i (color_block_i),
    .texel_idx_i   (texel_idx),
    .four_only_i   (fmt_i == FMT_DXT3),
    .rgba_o        (dxt_rgba)
  );

  // Pick the decode path for the format
  always_comb begin
    case (fmt_i)
      FMT_BGRA8: begin
        rgba_o.red   = color_block_i[23:16];
        rgba_o.green = color_block_i[15:8];
        rgba_o.blue  = color_block_i[7:0];
        rgba_o.alpha = color_block_i[31:24];
      end
      FMT_DXT1: begin
        rgba_o = dxt_rgba;
      end
      FMT_DXT3: begin
        rgba_o       = dxt_rgba;
        rgba_o.alpha = {alpha4, alpha4};
      end
      default: begin
        rgba_o.red   = expand5(color_block_i[15:11]);
        rgba_o.green = expand6(color_block_i[10:5]);
        rgba_o.blue  = expand5(color_block_i[4:0]);
        rgba_o.alpha = 8'd255;
      end
    endcase
  end

endmodule

>>> rtl/compressed_texel_decoder.sv
// ----------------------------------------------------------------------------
// compressed_texel_decoder: DXT1 / DXT3 / BGRA8 / R5G6B5 texel decoder
// Turns one fetched texel request into an RGBA8 texel.
// ----------------------------------------------------------------------------
// Each request is captured in an input register, decoded by the format
// logic and held in a result register, which drives the result channel;
// a texel thus passes the input register and then the result register.
// A new request is taken every cycle while the result side keeps
// draining. A stalled result holds the result register; once the input
// register is full as well, the request side backs up. The texture
// format register accepts a write every cycle and must only change while
// no request is in flight.
module compressed_texel_decoder (
  input  logic    clk_i,
  input  logic    rst_ni,
  ctd_cfg_if.sink    cfg_i,
  ctd_texel_if.sink  texel_i,
  ctd_rgba_if.source rgba_o
);
  import ctd_pkg::*;

  fmt_e        fmt_q;
  logic        in_valid_q;
  logic [63:0] color_block_q;
  logic [63:0] alpha_block_q;
  logic [1:0]  texel_col_q;
  logic [1:0]  texel_row_q;
  logic        out_valid_q;
  rgba_t       out_q;
  rgba_t       rgba_d;
  logic        out_advance;
  logic        in_advance;

  // Format register
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_BGRA8;
    end else if (cfg_i.valid) begin
      fmt_q <= fmt_e'(cfg_i.texture_format);
    end
  end

  // Flow control: advance when the next stage is free or draining
  assign out_advance   = !out_valid_q || rgba_o.ready;
  assign in_advance    = !in_valid_q || out_advance;
  assign texel_i.ready = in_advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_advance) begin
      in_valid_q <= texel_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_advance && texel_i.valid) begin
      color_block_q <= texel_i.color_block;
      alpha_block_q <= texel_i.alpha_block;
      texel_col_q   <= texel_i.texel_col;
      texel_row_q   <= texel_i.texel_row;
    end
  end

  // Decode
  ctd_format_mux u_mux (
    .fmt_i         (fmt_q),
    .color_block_i (color_block_q),
    .alpha_block_i (alpha_block_q),
    .texel_col_i   (texel_col_q),
    .texel_row_i   (texel_row_q),
    .rgba_o        (rgba_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_advance && in_valid_q) begin
      out_q <= rgba_d;
    end
  end

  assign rgba_o.valid = out_valid_q;
  assign rgba_o.red   = out_q.red;
  assign rgba_o.green = out_q.green;
  assign rgba_o.blue  = out_q.blue;
  assign rgba_o.alpha = out_q.alpha;

endmodule
